/* sv/pcds_pkg.sv */
// Shared types and constants for the per-channel delay statistics block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pcds_pkg;

    localparam int CHAN_W   = 4;
    localparam int DELAY_W  = 32;
    localparam int CNT_W    = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 168;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Kind of event carried on the input tuser bit.
    localparam logic OP_PRODUCE = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Number of quotient bits the divider produces, one per cycle.
    localparam int DIV_STEPS = 32;

    // One statistics table entry.
    typedef struct packed {
        logic [DELAY_W-1:0] peak_delay;
        logic [DELAY_W-1:0] mean_delay;
        logic [DELAY_W-1:0] least_delay;
        logic [CNT_W-1:0]   eaten_count;
        logic [CNT_W-1:0]   made_count;
    } stats_entry_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic               op;
        logic [CHAN_W-1:0]  channel;
        logic [DELAY_W-1:0] delay;
        logic               bad;
    } cmd_t;

    // Request to the iterative divider.
    typedef struct packed {
        logic                 start;
        logic [2*CNT_W-1:0]   dividend;
        logic [CNT_W-1:0]     divisor;
    } div_req_t;

    // Response of the iterative divider.
    typedef struct packed {
        logic               done;
        logic [CNT_W-1:0]   quotient;
    } div_rsp_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_CALC,
        B_MUL,
        B_DIV_START,
        B_DIV_WAIT,
        B_WRITE
    } back_state_t;

endpackage

/* sv/per_channel_delay_statistics.sv */
// Per-channel delay statistics: each event word updates one channel's
// made/eaten counts and min/avg/max delay and returns that channel's entry.
//
// Input channel (s_): tuser is the event kind (0 produced, 1 consumed),
// tdata holds the channel index and the consume delay (ms, 10 fraction bits).
// Output channel (m_): one word per event with the updated entry; tuser
// flags an out-of-range channel, in which case all statistics read zero.
//
// Sequence: an accepted word is queued, then the back end steps through its idle,
// read, calc and write states for a produce event, a first consume, a saturated
// consume or a bad channel; a consume that updates the running average adds the
// multiply and divide states around the 32-step restoring divider. The back end takes
// one event at a time; a two-entry queue ahead of it keeps accepting words.
//
// Reset: every table entry reads as zero right after reset through per-entry
// valid bits; no clearing pass is run. If the receiver stalls, the finished
// word waits in the output register, the back end holds in its write state
// and the queue fills, after which s_tready drops.
// Depends on pcds_pkg, pcds_front, pcds_back and pcds_div.
`timescale 1ns / 1ps

module per_channel_delay_statistics
    import pcds_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // channel[3:0], delay[35:4], zero pad
    input  logic                s_tuser,   // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // channel_out[3:0], made[35:4], eaten[67:36],
                                           // min[99:68], avg[131:100], max[163:132], pad
    output logic                m_tuser    // bad_channel
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    pcds_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    pcds_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // A rejected channel reports an all-zero entry.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[163:4] == '0)
        else $error("bad-channel word carries nonzero statistics");

    // The running average stays between the recorded extremes.
    a_avg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            m_tdata[99:68] <= m_tdata[131:100] && m_tdata[131:100] <= m_tdata[163:132])
        else $error("average outside min/max");

    // A valid channel's entry has counted at least the event just reported.
    a_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[35:4] != '0 || m_tdata[67:36] != '0)
        else $error("reported entry has no events counted");

    // Without any consume the delay statistics stay zero.
    a_no_consume: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67:36] == '0 |-> m_tdata[163:68] == '0)
        else $error("delay statistics set before any consume");
`endif

endmodule

/* sv/pcds_front.sv */
// Front end: accepts input words, flags out-of-range channels and queues commands.
// Depends on pcds_pkg.
`timescale 1ns / 1ps

module pcds_front
    import pcds_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // channel[3:0], delay[35:4], zero pad
    input  logic                s_tuser,   // op
    output logic                cmd_valid,
    output cmd_t                cmd,
    input  logic                cmd_pop
);

    localparam int CMP_W = 9;

    cmd_t        q_mem_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;
    cmd_t        in_cmd;

    // Classify the incoming word.
    always_comb begin
        in_cmd.op      = s_tuser;
        in_cmd.channel = s_tdata[CHAN_W-1:0];
        in_cmd.delay   = s_tdata[CHAN_W+DELAY_W-1:CHAN_W];
        in_cmd.bad     = ({{(CMP_W-CHAN_W){1'b0}}, s_tdata[CHAN_W-1:0]} >= CMP_W'(CHANNELS));
    end

    assign s_tready  = (count_reg != 2'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* sv/pcds_div.sv */
// Restoring divider, one quotient bit per cycle, for the running average.
// Depends on pcds_pkg; the quotient must fit in 32 bits (high dividend half below divisor).
`timescale 1ns / 1ps

module pcds_div
    import pcds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] quo_reg;
    logic [CNT_W-1:0] den_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W:0]   rem_sh;
    logic             ge;
    logic [CNT_W-1:0] rem_new;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[CNT_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_new = ge ? CNT_W'(rem_sh - {1'b0, den_reg}) : rem_sh[CNT_W-1:0];
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.dividend[2*CNT_W-1:CNT_W];
            quo_reg <= req.dividend[CNT_W-1:0];
            den_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_new;
            quo_reg <= {quo_reg[CNT_W-2:0], ge};
        end
    end

    // Step counter and completion flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 5'(DIV_STEPS - 1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* sv/pcds_back.sv */
// Back end: statistics table, update sequencer and output register.
// Depends on pcds_pkg and pcds_div.
`timescale 1ns / 1ps

module pcds_back
    import pcds_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // channel_out, made, eaten, min, avg, max, pad
    output logic                m_tuser    // bad_channel
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg;
    stats_entry_t       mem [CHANNELS];
    stats_entry_t       rd_data_reg;
    logic               rd_vld_reg;
    logic [CHANNELS-1:0] valid_reg;
    stats_entry_t       entry;
    stats_entry_t       upd_reg, upd_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [2*CNT_W-1:0] prod_reg;
    logic [2*CNT_W-1:0] prod_comb;
    logic [CNT_W-1:0]   n_dec;
    logic [CNT_W-1:0]   n_inc;
    logic               sat;
    logic [AW-1:0]      addr;
    logic               mem_we;
    logic               out_free;
    logic               out_load;
    logic               out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic               out_bad_reg;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    pcds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign addr     = AW'(cmd_reg.channel);
    assign out_free = !out_valid_reg || m_tready;

    // Table memory with registered read of the current command's entry.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr] <= upd_reg;
        end
        rd_data_reg <= mem[addr];
        rd_vld_reg  <= valid_reg[addr];
    end

    // Per-entry valid bits: an unwritten entry reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    // Entry arithmetic helpers.
    always_comb begin
        entry     = rd_vld_reg ? rd_data_reg : '0;
        sat       = (entry.eaten_count == COUNT_MAX);
        n_inc     = entry.eaten_count + 32'd1;
        n_dec     = n_reg - 32'd1;
        prod_comb = (2*CNT_W)'(upd_reg.mean_delay) * (2*CNT_W)'(n_dec);
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    state_next = B_READ;
                end
            end
            B_READ: begin
                state_next = B_CALC;
            end
            B_CALC: begin
                if (!cmd_reg.bad && cmd_reg.op == OP_CONSUME && !sat && n_inc != 32'd1) begin
                    state_next = B_MUL;
                end else begin
                    state_next = B_WRITE;
                end
            end
            B_MUL: begin
                state_next = B_DIV_START;
            end
            B_DIV_START: begin
                state_next = B_DIV_WAIT;
            end
            B_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = B_WRITE;
                end
            end
            B_WRITE: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb begin
        cmd_pop          = 1'b0;
        mem_we           = 1'b0;
        out_load         = 1'b0;
        upd_next         = upd_reg;
        n_next           = n_reg;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg + {{CNT_W{1'b0}}, cmd_reg.delay};
        div_req.divisor  = n_reg;
        case (state_reg)
            B_IDLE: begin
                cmd_pop = cmd_valid;
            end
            B_CALC: begin
                upd_next = entry;
                if (cmd_reg.bad) begin
                    upd_next = '0;
                end else if (cmd_reg.op == OP_PRODUCE) begin
                    if (entry.made_count != COUNT_MAX) begin
                        upd_next.made_count = entry.made_count + 32'd1;
                    end
                end else if (!sat && n_inc == 32'd1) begin
                    // First consume: every delay statistic takes this delay.
                    upd_next.eaten_count = n_inc;
                    upd_next.least_delay = cmd_reg.delay;
                    upd_next.peak_delay  = cmd_reg.delay;
                    upd_next.mean_delay  = cmd_reg.delay;
                end else begin
                    if (cmd_reg.delay > entry.peak_delay) begin
                        upd_next.peak_delay = cmd_reg.delay;
                    end
                    if (cmd_reg.delay < entry.least_delay) begin
                        upd_next.least_delay = cmd_reg.delay;
                    end
                    if (!sat) begin
                        upd_next.eaten_count = n_inc;
                        n_next               = n_inc;
                    end
                end
            end
            B_DIV_START: begin
                div_req.start = 1'b1;
            end
            B_DIV_WAIT: begin
                if (div_rsp.done) begin
                    upd_next.mean_delay = div_rsp.quotient;
                end
            end
            B_WRITE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    mem_we   = !cmd_reg.bad;
                end
            end
            default: begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            cmd_reg <= cmd;
        end
        upd_reg  <= upd_next;
        n_reg    <= n_next;
        prod_reg <= prod_comb;
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {4'd0, upd_reg.peak_delay, upd_reg.mean_delay, upd_reg.least_delay,
                             upd_reg.eaten_count, upd_reg.made_count, cmd_reg.channel};
            out_bad_reg  <= cmd_reg.bad;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

endmodule
